FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_sig, rstn_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond, msg) \
	`ASSERT_PROP(lbl, clk_sig, rstn_sig, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk_sig, rstn_sig, prop, msg)
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond, msg)

`endif

`endif

FILE: hw/rtl/ugcn_pkg.sv
package ugcn_pkg;

	// Field and port widths
	localparam int unsigned POS_W      = 32;
	localparam int unsigned T_W        = POS_W + 2;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CPA_W      = 7;
	localparam int unsigned IDX_W      = 18;
	localparam int unsigned SLOT_W     = 5;
	localparam int unsigned S_TDATA_W  = 3 * POS_W;
	localparam int unsigned M_TDATA_W  = 24;

	// Defaults
	localparam int unsigned MAX_CELLS_DEF = 64;
	localparam int unsigned QUEUE_DEPTH   = 2;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] WORLD_HALF_RST = 31'd524288;
	localparam logic [CFG_DATA_W-1:0] CELL_SIZE_RST  = 31'd65536;
	localparam logic [CPA_W-1:0]      CPA_RST        = 7'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORLD_HALF     = 2'd0,
		REG_CELL_SIZE      = 2'd1,
		REG_CELLS_PER_AXIS = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOCATE     = 1'b0,
		CMD_NEIGHBOURS = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_RUN,
		FE_DONE
	} fe_state_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] world_half;
		logic [CFG_DATA_W-1:0] cell_size;
		logic [CPA_W-1:0]      cells_per_axis;
	} cfg_t;

endpackage

FILE: hw/rtl/ugcn_fifo.sv
module ugcn_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != NW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + PW'(1));
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + PW'(1));
			end
			if (push && !pop) begin
				cnt_q <= NW'(cnt_q + NW'(1));
			end else if (pop && !push) begin
				cnt_q <= NW'(cnt_q - NW'(1));
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/ugcn_front.sv
module ugcn_front
	import ugcn_pkg::*;
#(
	parameter int unsigned MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
	parameter int unsigned ENT_W = 1 + 3 * ($clog2(MAX_CELLS_PER_AXIS + 2) + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [ENT_W-1:0]     push_data
);

	// Quotient bits: enough to tell every coordinate up to one past the grid
	localparam int unsigned QW   = $clog2(MAX_CELLS_PER_AXIS + 2);
	localparam int unsigned CW   = QW + 1;
	localparam int unsigned DW   = CFG_DATA_W + QW;
	localparam int unsigned CNTW = $clog2(QW);

	localparam logic signed [CW-1:0] C_MONE = '1;
	localparam logic signed [CW-1:0] C_MTWO = {{(CW - 1){1'b1}}, 1'b0};
	localparam logic signed [CW-1:0] C_SAT  = {1'b0, {QW{1'b1}}};

	fe_state_t state_q;
	fe_state_t state_d;

	logic                  s1_valid_q;
	logic                  cmd_s1;
	logic signed [T_W-1:0] t_s1 [3];

	logic [DW-1:0]          r_q    [3];
	logic [QW-1:0]          q_q    [3];
	logic                   fix_q  [3];
	logic signed [CW-1:0]   cfix_q [3];
	logic                   cmd_q;
	logic [DW-1:0]          d_q;
	logic [CNTW-1:0]        cnt_q;

	logic                   load;
	logic                   step;
	logic                   s_accept;
	logic [CFG_DATA_W-1:0]  cs_eff;
	logic signed [T_W-1:0]  nsum_w [3];
	logic                   ovf_w  [3];
	logic                   fix_w  [3];
	logic signed [CW-1:0]   cfix_w [3];
	logic signed [CW-1:0]   c_w    [3];

	assign cs_eff   = (cfg.cell_size == '0) ? CFG_DATA_W'(1) : cfg.cell_size;
	assign s_tready = !s1_valid_q || load;
	assign s_accept = s_tvalid && s_tready;

	// Input stage: offset each coordinate by half the world
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1 <= s_tuser;
			for (int a = 0; a < 3; a++) begin
				t_s1[a] <= $signed({{2{s_tdata[a*POS_W + POS_W - 1]}}, s_tdata[a*POS_W +: POS_W]})
					+ $signed({3'b000, cfg.world_half});
			end
		end
	end

	// Classify: negative offsets and quotients too wide for the quotient bits need no division
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nsum_w[a] = t_s1[a] + $signed({3'b000, cs_eff});
			ovf_w[a]  = DW'(t_s1[a][T_W-2:0]) >= {cs_eff, {QW{1'b0}}};
			fix_w[a]  = t_s1[a][T_W-1] || ovf_w[a];
			if (t_s1[a][T_W-1]) begin
				cfix_w[a] = nsum_w[a][T_W-1] ? C_MTWO : C_MONE;
			end else begin
				cfix_w[a] = C_SAT;
			end
		end
	end

	// Sequencer for the restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		step       = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			FE_IDLE: begin
				if (s1_valid_q) begin
					load    = 1'b1;
					state_d = FE_RUN;
				end
			end
			FE_RUN: begin
				step = 1'b1;
				if (cnt_q == '0) begin
					state_d = FE_DONE;
				end
			end
			FE_DONE: begin
				push_valid = 1'b1;
				if (push_ready) begin
					if (s1_valid_q) begin
						load    = 1'b1;
						state_d = FE_RUN;
					end else begin
						state_d = FE_IDLE;
					end
				end
			end
			default: begin
				state_d = FE_IDLE;
			end
		endcase
	end

	// Load the operands, then one quotient bit per axis each cycle in the run state
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd_s1;
			d_q   <= DW'({cs_eff, {(QW - 1){1'b0}}});
			cnt_q <= CNTW'(QW - 1);
			for (int a = 0; a < 3; a++) begin
				r_q[a]    <= DW'(t_s1[a][T_W-2:0]);
				q_q[a]    <= '0;
				fix_q[a]  <= fix_w[a];
				cfix_q[a] <= cfix_w[a];
			end
		end else if (step) begin
			d_q   <= d_q >> 1;
			cnt_q <= CNTW'(cnt_q - CNTW'(1));
			for (int a = 0; a < 3; a++) begin
				if (r_q[a] >= d_q) begin
					r_q[a] <= r_q[a] - d_q;
					q_q[a] <= {q_q[a][QW-2:0], 1'b1};
				end else begin
					q_q[a] <= {q_q[a][QW-2:0], 1'b0};
				end
			end
		end
	end

	// Pack coordinates for the queue
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			c_w[a] = fix_q[a] ? cfix_q[a] : $signed({1'b0, q_q[a]});
		end
	end

	assign push_data = {c_w[2], c_w[1], c_w[0], cmd_q};

endmodule

FILE: hw/rtl/ugcn_back.sv
module ugcn_back
	import ugcn_pkg::*;
#(
	parameter int unsigned MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
	parameter int unsigned ENT_W = 1 + 3 * ($clog2(MAX_CELLS_PER_AXIS + 2) + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [ENT_W-1:0]     pop_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	localparam int unsigned QW = $clog2(MAX_CELLS_PER_AXIS + 2);
	localparam int unsigned CW = QW + 1;
	localparam int unsigned NW = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int unsigned SW = ((CW > NW + 1) ? CW : NW + 1) + 2;

	localparam logic signed [SW-1:0] S_ONE  = 1;
	localparam logic signed [SW-1:0] S_ZERO = 0;
	localparam logic signed [SW-1:0] S_MONE = '1;

	// Effective cell count and its square
	logic [NW-1:0]    n_calc;
	logic [2*NW-1:0]  nsq_w;
	logic [NW-1:0]    n_q;
	logic [IDX_W-1:0] nn_q;

	always_comb begin
		if (cfg.cells_per_axis == '0) begin
			n_calc = NW'(1);
		end else if (32'(cfg.cells_per_axis) > 32'(MAX_CELLS_PER_AXIS)) begin
			n_calc = NW'(MAX_CELLS_PER_AXIS);
		end else begin
			n_calc = NW'(cfg.cells_per_axis);
		end
	end

	assign nsq_w = (2 * NW)'(n_calc) * (2 * NW)'(n_calc);

	always_ff @(posedge clk) begin
		n_q  <= n_calc;
		nn_q <= IDX_W'(nsq_w);
	end

	// Box of in-bounds offsets per axis
	logic                   cmd_w;
	logic signed [CW-1:0]   c_w     [3];
	logic signed [SW-1:0]   ce_w    [3];
	logic signed [SW-1:0]   m_w     [3];
	logic signed [SW-1:0]   cl_w    [3];
	logic signed [SW-1:0]   start_w [3];
	logic signed [2:0]      lo_w    [3];
	logic signed [2:0]      hi_w    [3];
	logic signed [1:0]      lo_sel  [3];
	logic signed [1:0]      hi_sel  [3];
	logic [NW-1:0]          co_w    [3];
	logic signed [SW-1:0]   nm1_w;
	logic                   empty_w;
	logic [IDX_W-1:0]       yn_w;
	logic [IDX_W-1:0]       znn_w;
	logic [SLOT_W-1:0]      slot0_w;

	assign cmd_w = pop_data[0];
	assign nm1_w = $signed(SW'(n_q)) - S_ONE;

	always_comb begin
		empty_w = 1'b0;
		for (int a = 0; a < 3; a++) begin
			c_w[a]  = pop_data[1 + a*CW +: CW];
			ce_w[a] = SW'(c_w[a]);
			m_w[a]  = nm1_w - ce_w[a];
			if (ce_w[a] >= S_ONE) begin
				lo_w[a] = -3'sd1;
			end else if (ce_w[a] == S_ZERO) begin
				lo_w[a] = 3'sd0;
			end else if (ce_w[a] == S_MONE) begin
				lo_w[a] = 3'sd1;
			end else begin
				lo_w[a] = 3'sd2;
			end
			if (m_w[a] >= S_ONE) begin
				hi_w[a] = 3'sd1;
			end else if (m_w[a] == S_ZERO) begin
				hi_w[a] = 3'sd0;
			end else if (m_w[a] == S_MONE) begin
				hi_w[a] = -3'sd1;
			end else begin
				hi_w[a] = -3'sd2;
			end
			if (ce_w[a] < S_ZERO) begin
				cl_w[a] = S_ZERO;
			end else if (ce_w[a] > nm1_w) begin
				cl_w[a] = nm1_w;
			end else begin
				cl_w[a] = ce_w[a];
			end
			if (cmd_w == CMD_NEIGHBOURS) begin
				start_w[a] = ce_w[a] + SW'(lo_w[a]);
				lo_sel[a]  = lo_w[a][1:0];
				hi_sel[a]  = hi_w[a][1:0];
				if (lo_w[a] > hi_w[a]) begin
					empty_w = 1'b1;
				end
			end else begin
				start_w[a] = cl_w[a];
				lo_sel[a]  = 2'sd0;
				hi_sel[a]  = 2'sd0;
			end
			co_w[a] = NW'(start_w[a]);
		end
	end

	assign yn_w    = IDX_W'(co_w[1]) * IDX_W'(n_q);
	assign znn_w   = IDX_W'(co_w[2]) * nn_q;
	assign slot0_w = SLOT_W'(9 * (int'(lo_sel[2]) + 1) + 3 * (int'(lo_sel[1]) + 1)
		+ int'(lo_sel[0]) + 1);

	// Setup stage
	logic              s1_valid_q;
	logic              empty_s1;
	logic signed [1:0] lo_s1 [3];
	logic signed [1:0] hi_s1 [3];
	logic [IDX_W-1:0]  x0_s1;
	logic [IDX_W-1:0]  yn_s1;
	logic [IDX_W-1:0]  znn_s1;
	logic [SLOT_W-1:0] slot0_s1;
	logic              s1_move;
	logic              walk_free;

	assign pop_ready = !s1_valid_q || s1_move;
	assign s1_move   = s1_valid_q && walk_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pop_ready) begin
			s1_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			empty_s1 <= empty_w;
			x0_s1    <= IDX_W'(co_w[0]);
			yn_s1    <= yn_w;
			znn_s1   <= znn_w;
			slot0_s1 <= slot0_w;
			for (int a = 0; a < 3; a++) begin
				lo_s1[a] <= lo_sel[a];
				hi_s1[a] <= hi_sel[a];
			end
		end
	end

	// Walker: steps through the box, x fastest, and doubles as output register
	logic              act_q;
	logic signed [1:0] dx_q;
	logic signed [1:0] dy_q;
	logic signed [1:0] dz_q;
	logic signed [1:0] lox_q;
	logic signed [1:0] loy_q;
	logic signed [1:0] hix_q;
	logic signed [1:0] hiy_q;
	logic signed [1:0] hiz_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  plane_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] srow_q;
	logic [SLOT_W-1:0] splane_q;
	logic [IDX_W-1:0]  idx0_w;
	logic [IDX_W-1:0]  row_nx;
	logic [IDX_W-1:0]  plane_nx;
	logic [SLOT_W-1:0] srow_nx;
	logic [SLOT_W-1:0] splane_nx;
	logic              last_now;
	logic              adv;

	assign last_now  = (dx_q == hix_q) && (dy_q == hiy_q) && (dz_q == hiz_q);
	assign walk_free = !act_q || (m_tready && last_now);
	assign adv       = act_q && m_tready && !last_now;
	assign idx0_w    = x0_s1 + yn_s1 + znn_s1;
	assign row_nx    = row_q + IDX_W'(n_q);
	assign plane_nx  = plane_q + nn_q;
	assign srow_nx   = srow_q + SLOT_W'(3);
	assign splane_nx = splane_q + SLOT_W'(9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (s1_move) begin
			act_q <= !empty_s1;
		end else if (act_q && m_tready && last_now) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			dx_q     <= lo_s1[0];
			dy_q     <= lo_s1[1];
			dz_q     <= lo_s1[2];
			lox_q    <= lo_s1[0];
			loy_q    <= lo_s1[1];
			hix_q    <= hi_s1[0];
			hiy_q    <= hi_s1[1];
			hiz_q    <= hi_s1[2];
			idx_q    <= idx0_w;
			row_q    <= idx0_w;
			plane_q  <= idx0_w;
			slot_q   <= slot0_s1;
			srow_q   <= slot0_s1;
			splane_q <= slot0_s1;
		end else if (adv) begin
			if (dx_q != hix_q) begin
				dx_q   <= dx_q + 2'sd1;
				idx_q  <= idx_q + IDX_W'(1);
				slot_q <= slot_q + SLOT_W'(1);
			end else if (dy_q != hiy_q) begin
				dx_q   <= lox_q;
				dy_q   <= dy_q + 2'sd1;
				idx_q  <= row_nx;
				row_q  <= row_nx;
				slot_q <= srow_nx;
				srow_q <= srow_nx;
			end else begin
				dx_q     <= lox_q;
				dy_q     <= loy_q;
				dz_q     <= dz_q + 2'sd1;
				idx_q    <= plane_nx;
				row_q    <= plane_nx;
				plane_q  <= plane_nx;
				slot_q   <= splane_nx;
				srow_q   <= splane_nx;
				splane_q <= splane_nx;
			end
		end
	end

	assign m_tvalid = act_q;
	assign m_tlast  = last_now;
	assign m_tdata  = {1'b0, slot_q, idx_q};

endmodule

FILE: hw/rtl/uniform_grid_cell_neighbourhood_unit.sv
// Uniform grid cell indexer. Each input transaction carries a signed Q16.16 position
// (tdata) and a command (tuser: 0 locate, 1 neighbourhood). Per axis the cell
// coordinate is floor((pos + world_half) / cell_size). Locate returns one transaction
// with the clamped linear index x + y*N + z*N*N and slot 13; neighbourhood returns
// one transaction per in-bounds cell of the 3x3x3 block, z outermost and x fastest,
// possibly none at all, with tlast on the final one. The front end runs a restoring
// divider on all three axes at once, and its input register can take the next
// transaction while the current one is being divided; the back end walks only the
// in-bounds box and gives one result per cycle while m_tready is high. A transaction
// yields one result in locate mode and up to 27 in neighbourhood mode. A two entry
// queue and the result register let a new transaction enter while results are still
// waiting to be taken. Write configuration only while the block is idle.
module uniform_grid_cell_neighbourhood_unit
	import ugcn_pkg::*;
#(
	parameter int unsigned MAX_CELLS_PER_AXIS = MAX_CELLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z
	input  logic                  s_tuser,   // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // cell_index, neighbour_slot, zero pad
	output logic                  m_tlast
);

	`include "assert_macros.svh"

	localparam int unsigned QW    = $clog2(MAX_CELLS_PER_AXIS + 2);
	localparam int unsigned ENT_W = 1 + 3 * (QW + 1);

	cfg_t cfg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.world_half     <= WORLD_HALF_RST;
			cfg_q.cell_size      <= CELL_SIZE_RST;
			cfg_q.cells_per_axis <= CPA_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WORLD_HALF:     cfg_q.world_half     <= cfg_wdata;
				REG_CELL_SIZE:      cfg_q.cell_size      <= cfg_wdata;
				REG_CELLS_PER_AXIS: cfg_q.cells_per_axis <= cfg_wdata[CPA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic             push_valid;
	logic             push_ready;
	logic [ENT_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [ENT_W-1:0] pop_data;

	ugcn_front #(
		.MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
		.ENT_W              (ENT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ugcn_fifo #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ugcn_back #(
		.MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
		.ENT_W              (ENT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Results of one neighbourhood come without gaps and in rising slot order
	logic [SLOT_W-1:0] m_slot;
	logic              out_step;
	logic              far_open;

	assign m_slot   = m_tdata[IDX_W +: SLOT_W];
	assign out_step = m_tvalid && m_tready && !m_tlast;
	assign far_open = m_tvalid && !m_tlast && (m_slot == SLOT_W'(26));

	`ASSERT_PROP(a_no_gap, clk, arst_n, out_step |=> m_tvalid, "gap inside a run")
	`ASSERT_PROP(a_slot_rise, clk, arst_n, out_step |=> (m_slot > $past(m_slot)), "slot order broken")
	`ASSERT_NEVER(a_corner_last, clk, arst_n, far_open, "far corner not last")

endmodule
